/* rtl/core/fts_pkg.sv */
// Package: shared types and constants for the fixed timestep scheduler.
package fts_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned STAMP_W = 63;
   localparam int unsigned STEP_W  = 30;
   localparam int unsigned CAP_W   = 26;
   localparam int unsigned SUB_W   = 6;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 30;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_NS      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_CAP_NS = 1'b1;

   localparam logic [STEP_W-1:0] STEP_RESET = 30'd4166666;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 26'd25000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CREDIT,
      ST_COUNT,
      ST_DIV,
      ST_EMIT
   } fts_state_type;

endpackage

/* rtl/core/fts_ifs.sv */
// Interfaces: request, response and configuration channels.
interface fts_req_if;
   logic                           valid;
   logic                           ready;
   logic [fts_pkg::STAMP_W-1:0]    frame_start_ns;
   logic [fts_pkg::STAMP_W-1:0]    frame_index;
   modport source (output valid, output frame_start_ns, output frame_index, input ready);
   modport sink   (input valid, input frame_start_ns, input frame_index, output ready);
endinterface

interface fts_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fts_pkg::STAMP_W-1:0]    sim_time_ns;
   logic signed [fts_pkg::DATA_W-1:0] host_time_ns;
   logic signed [fts_pkg::DATA_W-1:0] host_step_ns;
   logic [fts_pkg::SUB_W-1:0]      subframe_index;
   logic [fts_pkg::STAMP_W-1:0]    frame_tag;
   logic signed [fts_pkg::DATA_W-1:0] frame_duration_ns;
   logic                           last_step;
   modport source (output valid, output sim_time_ns, output host_time_ns,
                   output host_step_ns, output subframe_index, output frame_tag,
                   output frame_duration_ns, output last_step, input ready);
   modport sink   (input valid, input sim_time_ns, input host_time_ns,
                   input host_step_ns, input subframe_index, input frame_tag,
                   input frame_duration_ns, input last_step, output ready);
endinterface

interface fts_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fts_pkg::CSR_IDX_W-1:0]   index;
   logic [fts_pkg::CSR_DAT_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fts_div.sv */
// Radix-2 restoring divider: signed 64-bit numerator by a small positive count.
module fts_div #(
   parameter int unsigned DEN_W = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [fts_pkg::DATA_W-1:0] numer,
   input  logic [DEN_W-1:0]                  denom,
   output logic                              done,
   output logic signed [fts_pkg::DATA_W-1:0] quotient
);

   localparam int unsigned BIT_W = $clog2(fts_pkg::DATA_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       neg_ff, neg_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [DEN_W-1:0]           rem_ff, rem_in;
   logic [fts_pkg::DATA_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]             rem_shift;
   logic [DEN_W:0]             diff;

   assign rem_shift = {rem_ff, quo_ff[fts_pkg::DATA_W-1]};
   assign diff      = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      bit_in  = bit_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = numer[fts_pkg::DATA_W-1];
         bit_in  = '0;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = numer[fts_pkg::DATA_W-1] ? (-numer) : numer;
      end else if (busy_ff) begin
         // one quotient bit per cycle; no borrow means the count fits
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[fts_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[fts_pkg::DATA_W-2:0], 1'b0};
         end
         bit_in = bit_ff + 1'b1;
         if (bit_ff == BIT_W'(fts_pkg::DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      bit_ff <= bit_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (-quo_ff) : quo_ff;

endmodule

/* rtl/core/fixed_timestep_scheduler.sv */
// Top level: fixed timestep scheduler with frame credit, step count and host time.
//
// Usage
//   req_ch carries one frame-start timestamp and a frame number per transfer.
//   rsp_ch carries the step results of that frame, 0 to MAX_STEPS of them, in
//   order; last_step marks the final one. A frame that earns no step gives no
//   result but is still taken as the previous frame start.
//   csr_ch writes step_ns (index 0) or frame_cap_ns (index 1); it is always
//   ready and must be written only while the block is idle.
// Flow
//   One frame at a time: req_ch.ready is high only when idle. A frame passes
//   through capture, credit, counting of its N steps (one compare and subtract
//   per step), then, if N > 0, the serial divider (one quotient bit per cycle
//   for the 64-bit duration, then the quotient is taken) and N result
//   transfers.
// Reset
//   Synchronous, active high: registers return to step 4166666 ns and cap
//   25000000 ns; previous start, accumulator and sim time clear to zero.
// Stall
//   A result holds on rsp_ch until it is taken; the sequencer waits and no
//   new frame is accepted until the last result of the frame is transferred.
module fixed_timestep_scheduler #(
   parameter int unsigned MAX_STEPS = 64
) (
   input  logic       clock,
   input  logic       reset,
   fts_req_if.sink    req_ch,
   fts_rsp_if.source  rsp_ch,
   fts_csr_if.sink    csr_ch
);

   localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);
   localparam int unsigned DW    = fts_pkg::DATA_W;

   fts_pkg::fts_state_type state_ff, state_in;

   // configuration
   logic [fts_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [fts_pkg::CAP_W-1:0]   cap_ff, cap_in;

   // architectural state
   logic [DW-1:0]               prev_ff, prev_in;
   logic signed [DW-1:0]        acc_ff, acc_in;
   logic [DW-1:0]               sim_ff, sim_in;

   // per-frame working registers
   logic [fts_pkg::STAMP_W-1:0] tag_ff, tag_in;
   logic signed [DW-1:0]        dur_ff, dur_in;
   logic [DW-1:0]               host_ff, host_in;
   logic signed [DW-1:0]        hstep_ff, hstep_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            k_ff, k_in;

   logic                        req_xfer;
   logic                        rsp_xfer;
   logic                        csr_xfer;
   logic                        step_due;
   logic                        is_last;
   logic                        div_start;
   logic                        div_done;
   logic signed [DW-1:0]        div_quo;
   logic signed [DW-1:0]        step_wide;
   logic signed [DW-1:0]        cap_wide;
   logic signed [DW-1:0]        credit;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign rsp_xfer = rsp_ch.valid && rsp_ch.ready;
   assign csr_xfer = csr_ch.valid && csr_ch.ready;

   assign step_wide = $signed({{(DW - fts_pkg::STEP_W){1'b0}}, step_ff});
   assign cap_wide  = $signed({{(DW - fts_pkg::CAP_W){1'b0}}, cap_ff});
   assign credit    = (dur_ff > cap_wide) ? cap_wide : dur_ff;

   // another step is due while under the limit and the credit covers one step
   assign step_due = (cnt_ff < CNT_W'(MAX_STEPS)) && (acc_ff >= step_wide);
   assign is_last  = ((k_ff + 1'b1) == cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (req_xfer) state_in = fts_pkg::ST_CREDIT;
         end
         fts_pkg::ST_CREDIT: begin
            state_in = fts_pkg::ST_COUNT;
         end
         fts_pkg::ST_COUNT: begin
            if (!step_due) begin
               state_in = (cnt_ff == '0) ? fts_pkg::ST_IDLE : fts_pkg::ST_DIV;
            end
         end
         fts_pkg::ST_DIV: begin
            if (div_done) state_in = fts_pkg::ST_EMIT;
         end
         fts_pkg::ST_EMIT: begin
            if (rsp_xfer && is_last) state_in = fts_pkg::ST_IDLE;
         end
         default: state_in = fts_pkg::ST_IDLE;
      endcase
   end

   // handshake and divider control outputs
   always_comb begin
      req_ch.ready = (state_ff == fts_pkg::ST_IDLE);
      rsp_ch.valid = (state_ff == fts_pkg::ST_EMIT);
      csr_ch.ready = 1'b1;
      div_start    = (state_ff == fts_pkg::ST_COUNT) && !step_due && (cnt_ff != '0);
   end

   // datapath next values
   always_comb begin
      step_in  = step_ff;
      cap_in   = cap_ff;
      prev_in  = prev_ff;
      acc_in   = acc_ff;
      sim_in   = sim_ff;
      tag_in   = tag_ff;
      dur_in   = dur_ff;
      host_in  = host_ff;
      hstep_in = hstep_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;

      if (csr_xfer) begin
         case (csr_ch.index)
            fts_pkg::CSR_STEP_NS:      step_in = csr_ch.data[fts_pkg::STEP_W-1:0];
            fts_pkg::CSR_FRAME_CAP_NS: cap_in  = csr_ch.data[fts_pkg::CAP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (req_xfer) begin
               // duration wraps mod 2^64; host time starts at the old frame start
               dur_in  = $signed({1'b0, req_ch.frame_start_ns} - prev_ff);
               host_in = prev_ff;
               prev_in = {1'b0, req_ch.frame_start_ns};
               tag_in  = req_ch.frame_index;
            end
         end
         fts_pkg::ST_CREDIT: begin
            // negative durations are credited as they are
            acc_in = acc_ff + credit;
            cnt_in = '0;
         end
         fts_pkg::ST_COUNT: begin
            if (step_due) begin
               acc_in = acc_ff - step_wide;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         fts_pkg::ST_DIV: begin
            if (div_done) begin
               hstep_in = div_quo;
               k_in     = '0;
            end
         end
         fts_pkg::ST_EMIT: begin
            if (rsp_xfer) begin
               k_in    = k_ff + 1'b1;
               sim_in  = sim_ff + {{(DW - fts_pkg::STEP_W){1'b0}}, step_ff};
               host_in = host_ff + hstep_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fts_pkg::ST_IDLE;
         step_ff  <= fts_pkg::STEP_RESET;
         cap_ff   <= fts_pkg::CAP_RESET;
         prev_ff  <= '0;
         acc_ff   <= '0;
         sim_ff   <= '0;
         cnt_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cap_ff   <= cap_in;
         prev_ff  <= prev_in;
         acc_ff   <= acc_in;
         sim_ff   <= sim_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
      tag_ff   <= tag_in;
      dur_ff   <= dur_in;
      host_ff  <= host_in;
      hstep_ff <= hstep_in;
   end

   // host step = uncapped duration / step count, truncated toward zero
   fts_div #(
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (dur_ff),
      .denom    (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_ch.sim_time_ns       = sim_ff[fts_pkg::STAMP_W-1:0];
   assign rsp_ch.host_time_ns      = $signed(host_ff);
   assign rsp_ch.host_step_ns      = hstep_ff;
   assign rsp_ch.subframe_index    = fts_pkg::SUB_W'(k_ff);
   assign rsp_ch.frame_tag         = tag_ff;
   assign rsp_ch.frame_duration_ns = dur_ff;
   assign rsp_ch.last_step         = is_last;

   // one frame at a time: never ready for a frame while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("frame accepted while results pending");

   // the step being shown lies inside the counted range
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (k_ff < cnt_ff))
      else $error("subframe index beyond step count");

   // the final result returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_ch.last_step) |=> req_ch.ready)
      else $error("not idle after last step");

   // divider results arrive only while the sequencer waits for them
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == fts_pkg::ST_DIV))
      else $error("divider done outside division phase");

   // a frame with steps never goes straight back to idle from counting
   a_count_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == fts_pkg::ST_COUNT) && !step_due && (cnt_ff != '0))
         |=> (state_ff == fts_pkg::ST_DIV))
      else $error("counted steps dropped");

endmodule

/* sim/tb.sv */
// Testbench for fixed_timestep_scheduler: directed and random frames checked against a step predictor.
module tb;

   localparam int          STEP_LIMIT   = 64;       // MAX_STEPS of the block
   localparam int          QUIET_CYCLES = 200;      // > one frame of capture, count and divide
   localparam int          CYCLE_LIMIT  = 2000000;
   localparam logic [62:0] STAMP_MAX    = {63{1'b1}};

   typedef struct packed {
      logic [62:0] start_ns;
      logic [62:0] index;
   } frame_item_type;

   // one step result as it leaves on rsp_ch
   typedef struct packed {
      logic [62:0] sim_time_ns;
      logic [63:0] host_time_ns;
      logic [63:0] host_step_ns;
      logic [5:0]  subframe_index;
      logic [62:0] frame_tag;
      logic [63:0] frame_duration_ns;
      logic        last_step;
   } step_result_type;

   logic clock = 1'b0;
   logic reset;

   fts_req_if req_ch ();
   fts_rsp_if rsp_ch ();
   fts_csr_if csr_ch ();

   fixed_timestep_scheduler #(.MAX_STEPS(STEP_LIMIT)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // frames waiting for the driver, step results waiting for the block
   frame_item_type  pending_frames[$];
   step_result_type steps_due[$];
   int           frames_issued  = 0;
   int           frames_taken   = 0;
   int           mismatches     = 0;
   int           send_gap_pct   = 9;
   int           recv_stall_pct = 51;
   logic [62:0]  gen_start      = '0;   // timestamp of the last frame queued

   // scheduler state as the predictor sees it
   logic [63:0]                last_start = '0;
   logic [63:0]                credit_acc = '0;   // signed accumulator, wraps mod 2^64
   logic [63:0]                sim_clock  = '0;
   logic [fts_pkg::STEP_W-1:0] cur_step   = fts_pkg::STEP_RESET;
   logic [fts_pkg::CAP_W-1:0]  cur_cap    = fts_pkg::CAP_RESET;

   // Credit one frame and queue the step results it earns.
   function automatic void predict_steps(input logic [62:0] start_ns, input logic [62:0] tag);
      logic [63:0]     dur, credit, mag, quot, hstep, host;
      logic [63:0]     sim_at [STEP_LIMIT];
      int              n, k;
      step_result_type r;
      dur = {1'b0, start_ns} - last_start;
      // cap compare is signed: a backward frame goes in uncapped
      credit = ($signed(dur) > $signed({38'd0, cur_cap})) ? {38'd0, cur_cap} : dur;
      credit_acc = credit_acc + credit;
      n = 0;
      // step of zero never drains the credit, so the step limit ends the loop
      while (n < STEP_LIMIT && $signed(credit_acc) >= $signed({34'd0, cur_step})) begin
         sim_at[n]  = sim_clock;
         credit_acc = credit_acc - {34'd0, cur_step};
         sim_clock  = sim_clock + {34'd0, cur_step};
         n++;
      end
      if (n > 0) begin
         // truncate toward zero: divide the magnitude, restore the sign
         mag   = dur[63] ? -dur : dur;
         quot  = mag / 64'(n);
         hstep = dur[63] ? -quot : quot;
         host  = last_start;
         for (k = 0; k < n; k++) begin
            r.sim_time_ns       = sim_at[k][62:0];
            r.host_time_ns      = host;
            r.host_step_ns      = hstep;
            r.subframe_index    = 6'(k);
            r.frame_tag         = tag;
            r.frame_duration_ns = dur;
            r.last_step         = (k == n - 1);
            steps_due = {steps_due, r};
            host = host + hstep;
         end
      end
      last_start = {1'b0, start_ns};
   endfunction

   // Driver: next frame goes out once the current one is transferred.
   always @(posedge clock) begin : req_driver
      frame_item_type head;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_frames.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            head = pending_frames.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.frame_start_ns <= head.start_ns;
            req_ch.frame_index    <= head.index;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls at random
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: frame transfers feed the predictor, step transfers are checked in order,
   // register transfers update the predictor's copy of the registers.
   always @(posedge clock) begin : step_monitor
      step_result_type seen, want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               fts_pkg::CSR_STEP_NS:      cur_step = csr_ch.data[fts_pkg::STEP_W-1:0];
               fts_pkg::CSR_FRAME_CAP_NS: cur_cap  = csr_ch.data[fts_pkg::CAP_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            frames_taken++;
            predict_steps(req_ch.frame_start_ns, req_ch.frame_index);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.sim_time_ns       = rsp_ch.sim_time_ns;
            seen.host_time_ns      = rsp_ch.host_time_ns;
            seen.host_step_ns      = rsp_ch.host_step_ns;
            seen.subframe_index    = rsp_ch.subframe_index;
            seen.frame_tag         = rsp_ch.frame_tag;
            seen.frame_duration_ns = rsp_ch.frame_duration_ns;
            seen.last_step         = rsp_ch.last_step;
            if (steps_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("step result with none due: tag %0d sub %0d sim %0d",
                           seen.frame_tag, seen.subframe_index, seen.sim_time_ns);
            end else begin
               want = steps_due.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("step result mismatch, tag %0d sub %0d",
                              want.frame_tag, want.subframe_index);
                     $display("  want sim %0d host %0d hstep %0d sub %0d tag %0d dur %0d last %0b",
                              want.sim_time_ns, $signed(want.host_time_ns),
                              $signed(want.host_step_ns), want.subframe_index, want.frame_tag,
                              $signed(want.frame_duration_ns), want.last_step);
                     $display("  got  sim %0d host %0d hstep %0d sub %0d tag %0d dur %0d last %0b",
                              seen.sim_time_ns, $signed(seen.host_time_ns),
                              $signed(seen.host_step_ns), seen.subframe_index, seen.frame_tag,
                              $signed(seen.frame_duration_ns), seen.last_step);
                  end
               end
            end
         end
      end
   end

   task automatic push_at(input logic [62:0] start_ns, input logic [62:0] tag);
      frame_item_type it;
      it.start_ns = start_ns;
      it.index    = tag;
      pending_frames = {pending_frames, it};
      frames_issued++;
      gen_start = start_ns;
   endtask

   // dur is a 64-bit two's complement offset from the last queued timestamp
   task automatic push_after(input logic [63:0] dur);
      push_at(gen_start + dur[62:0],
              $urandom_range(1) ? 63'({$urandom, $urandom}) : 63'(frames_issued));
   endtask

   // Drained: every frame transferred, every step result in, then a quiet stretch
   // so a frame that earned no step has finished too.
   task automatic wait_idle();
      do @(posedge clock); while (frames_taken != frames_issued || steps_due.size() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [fts_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fts_pkg::CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Random frames: mostly runs of plausible frame durations, some backward jitter,
   // rare big forward jumps, and the full-range wrap pattern that restores the credit.
   task automatic gen_frames(input int count, input logic [29:0] step, input logic [25:0] cap);
      int          left, pick, burst, j;
      logic [63:0] dur, room;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(99);
         room = {1'b0, STAMP_MAX} - {1'b0, gen_start};
         if ((pick < 8 || room < (64'd1 << 40)) && left >= 4) begin
            // two backward jumps of 2^63-1 sum to 2 modulo 2^64
            push_at(STAMP_MAX, 63'({$urandom, $urandom}));
            push_at('0, 63'({$urandom, $urandom}));
            push_at(STAMP_MAX, 63'({$urandom, $urandom}));
            push_at('0, 63'({$urandom, $urandom}));
            left -= 4;
         end else if (pick < 12) begin
            dur = {$urandom, $urandom} % (room + 64'd1);
            push_after(dur);
            left--;
         end else if (pick < 27) begin
            dur = 64'($urandom_range(1, 200000));
            if (dur > {1'b0, gen_start}) dur = {1'b0, gen_start};
            push_after(-dur);
            left--;
         end else begin
            burst = $urandom_range(1, 8);
            if (burst > left) burst = left;
            for (j = 0; j < burst; j++) begin
               case ($urandom_range(5))
                  0: dur = 64'($urandom_range(0, step));
                  1: dur = {34'd0, step} * 64'($urandom_range(1, 3))
                           + 64'($urandom_range(0, 2)) - 64'd1;
                  2: dur = {38'd0, cap} + 64'($urandom_range(0, 2)) - 64'd1;
                  3: dur = 64'($urandom_range(0, cap));
                  4: dur = 64'($urandom);
                  default: dur = 64'd16666666 + 64'($urandom_range(0, 400000)) - 64'd200000;
               endcase
               room = {1'b0, STAMP_MAX} - {1'b0, gen_start};
               if (!dur[63] && dur > room) dur = room;
               if (dur[63] && -dur > {1'b0, gen_start}) dur = '0;
               push_after(dur);
            end
            left -= burst;
         end
      end
   endtask

   task automatic run_phase(input logic [29:0] step, input logic [29:0] cap_word,
                            input int gap, input int stall, input int count);
      wait_idle();
      write_reg(fts_pkg::CSR_STEP_NS, step);
      write_reg(fts_pkg::CSR_FRAME_CAP_NS, cap_word);
      send_gap_pct   = gap;
      recv_stall_pct = stall;
      gen_frames(count, step, cap_word[25:0]);
   endtask

   initial begin : stimulus
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.frame_start_ns = '0;
      req_ch.frame_index    = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = fts_pkg::CSR_STEP_NS;
      csr_ch.data           = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset registers: step 4166666, cap 25000000
      push_at('0, '0);                            // zero duration, nothing due
      push_after(64'd4166666);                    // credit exactly one step
      push_at(gen_start + 63'd4166665, STAMP_MAX);  // one short of a step
      push_after(64'd1);
      push_after(64'd25000000);                   // duration equal to the cap
      push_after(64'd25000001);                   // just over the cap
      push_at(STAMP_MAX, 63'h5555555555555555);   // huge forward jump, capped
      push_at('0, 63'h2AAAAAAAAAAAAAAA);          // huge backward frame
      push_at(STAMP_MAX, '0);
      push_at('0, STAMP_MAX);                     // credit wraps back, negative host step
      push_after(64'd1000);
      push_after(-64'd500);                       // small backward frame

      // short step, widest cap: step limit reached, leftover credit carries over
      wait_idle();
      write_reg(fts_pkg::CSR_STEP_NS, 30'd1000000);
      write_reg(fts_pkg::CSR_FRAME_CAP_NS, 30'h3FFFFFFF);
      push_after(64'd70000000);
      push_after(64'd0);

      // zero step and zero cap: full step count while the credit is not negative
      wait_idle();
      write_reg(fts_pkg::CSR_STEP_NS, 30'd0);
      write_reg(fts_pkg::CSR_FRAME_CAP_NS, 30'd0);
      push_after(64'd0);
      push_after(-64'd1000);
      push_after(-64'd200000);
      push_after(64'd5000);

      // random part; sender 9 / receiver 51, then swapped, then no idling
      run_phase(30'd4166666, 30'd25000000, 9, 51, 60);
      run_phase(30'($urandom_range(1000000, 100000000)), 30'($urandom_range(0, 64000000)),
                9, 51, 50);
      run_phase(30'd1000000, 30'd64000000, 51, 9, 40);
      run_phase(30'h3FFFFFFF, 30'h3FFFFFFF, 51, 9, 60);   // results are rare here
      run_phase(30'd0, 30'($urandom_range(0, 64000000)), 0, 0, 30);
      run_phase(30'($urandom_range(1000000, 1000000000)), 30'($urandom), 0, 0, 70);

      wait_idle();
      if (mismatches == 0 && steps_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

endmodule
